@@ sv/gcut_pkg.sv @@
// ----------------------------------------------------------------------------
// gcut_pkg: shared types and constants for the guillotine cut solver
// Field widths, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package gcut_pkg;

    // Fixed widths of the request and response fields.
    localparam int SIDE_W   = 5;
    localparam int PIECE_W  = 9;
    localparam int RESULT_W = 9;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENTRY,
        ST_LOOKUP,
        ST_CAND,
        ST_DRAIN,
        ST_WRITE,
        ST_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write zero at the clear pointer and advance it
        logic load;       // capture the request and start the sweep
        logic ent_adv;    // current table entry is settled, move to the next
        logic ent_init;   // start the split search for the current entry
        logic cand_step;  // issue one split candidate and advance the iterator
        logic ent_wr;     // store the search result for the current entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;       // clear pointer is at the last table entry
        logic req_invalid;    // request on the input channel is out of range
        logic ent_infeasible; // current entry has more pieces than cells
        logic ent_known;      // table read of the current entry is non-zero
        logic ent_single;     // current entry asks for a single piece
        logic cand_last;      // iterator is at the final split candidate
        logic sweep_last;     // current entry is the requested one
    } t_sts;

endpackage

@@ sv/gcut_if.sv @@
// ----------------------------------------------------------------------------
// gcut_req_if / gcut_rsp_if: request and response channels
// Valid/ready channels; a beat moves at a rising edge with both high.
// ----------------------------------------------------------------------------
interface gcut_req_if;
    import gcut_pkg::*;

    logic               valid;
    logic               ready;
    logic [SIDE_W-1:0]  rect_width;
    logic [SIDE_W-1:0]  rect_height;
    logic [PIECE_W-1:0] piece_count;

    modport source (output valid, output rect_width, output rect_height,
                    output piece_count, input ready);
    modport sink   (input valid, input rect_width, input rect_height,
                    input piece_count, output ready);
endinterface

interface gcut_rsp_if;
    import gcut_pkg::*;

    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] max_piece_area;
    logic                invalid;

    modport source (output valid, output max_piece_area, output invalid, input ready);
    modport sink   (input valid, input max_piece_area, input invalid, output ready);
endinterface

@@ sv/gcut_ram.sv @@
// ----------------------------------------------------------------------------
// gcut_ram: generic single-write, dual-read memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module gcut_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

@@ sv/gcut_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcut_ctrl: sequencing controller for the guillotine cut solver
// Runs the table clearing pass, the bottom-up sweep over table entries and
// the per-entry split search, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module gcut_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gcut_pkg::t_sts i_sts,
    output gcut_pkg::t_cmd o_cmd
);
    import gcut_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.req_invalid ? ST_RESP : ST_ENTRY;
                end
            end
            ST_ENTRY: begin
                // The table read for this entry is issued in this cycle.
                if (i_sts.ent_infeasible) begin
                    o_cmd.ent_adv = 1'b1;
                    n_state       = i_sts.sweep_last ? ST_RESP : ST_ENTRY;
                end else begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_sts.ent_known) begin
                    o_cmd.ent_adv = 1'b1;
                    n_state       = i_sts.sweep_last ? ST_RESP : ST_ENTRY;
                end else begin
                    o_cmd.ent_init = 1'b1;
                    n_state        = i_sts.ent_single ? ST_WRITE : ST_CAND;
                end
            end
            ST_CAND: begin
                o_cmd.cand_step = 1'b1;
                if (i_sts.cand_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last candidate's read data is folded in at this edge.
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.ent_wr  = 1'b1;
                o_cmd.ent_adv = 1'b1;
                n_state       = i_sts.sweep_last ? ST_RESP : ST_ENTRY;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A response only appears right after a rejected request or the end of a sweep.
    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.load || o_cmd.ent_adv))
        else $error("response raised without a finished request");

    // The split search runs without a gap until its final candidate.
    a_cand_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cand_step && !i_sts.cand_last) |=> o_cmd.cand_step)
        else $error("split search stopped before its last candidate");
endmodule

@@ sv/gcut_dp.sv @@
// ----------------------------------------------------------------------------
// gcut_dp: datapath of the guillotine cut solver
// Holds the request, the sweep and split iterators, the running minimum and
// the answer table, and reports status to the controller.
// ----------------------------------------------------------------------------
module gcut_dp #(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [gcut_pkg::SIDE_W-1:0]     i_rect_width,
    input  logic [gcut_pkg::SIDE_W-1:0]     i_rect_height,
    input  logic [gcut_pkg::PIECE_W-1:0]    i_piece_count,
    output logic [gcut_pkg::RESULT_W-1:0]   o_max_piece_area,
    output logic                            o_invalid,
    input  gcut_pkg::t_cmd                  i_cmd,
    output gcut_pkg::t_sts                  o_sts
);
    import gcut_pkg::*;

    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH  = CELLS * CELLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AREA_W = $clog2(CELLS + 1);
    localparam int PROD_W = 2 * SIDE_W;

    localparam logic DIR_VERT  = 1'b0;
    localparam logic DIR_HORIZ = 1'b1;

    // Table slot of the answer for a w by h rectangle cut into p pieces.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [SIDE_W-1:0]  w,
                                                  input logic [SIDE_W-1:0]  h,
                                                  input logic [PIECE_W-1:0] p);
        logic [31:0] s;
        s = (32'(p) - 32'd1) * CELLS + (32'(h) - 32'd1) * MAX_WIDTH + (32'(w) - 32'd1);
        return s[ADDR_W-1:0];
    endfunction

    // Request.
    logic [SIDE_W-1:0]  r_w, n_w;
    logic [SIDE_W-1:0]  r_h, n_h;
    logic [PIECE_W-1:0] r_p, n_p;
    logic               r_inv, n_inv;
    // Sweep position: current table entry.
    logic [SIDE_W-1:0]  r_cw, n_cw;
    logic [SIDE_W-1:0]  r_ch, n_ch;
    logic [PIECE_W-1:0] r_cp, n_cp;
    // Split iterator.
    logic               r_dir, n_dir;
    logic [SIDE_W-1:0]  r_i, n_i;
    logic [PIECE_W-1:0] r_j, n_j;
    logic               r_pend, n_pend;
    logic [AREA_W-1:0]  r_best, n_best;
    logic [AREA_W-1:0]  r_ans, n_ans;
    logic [ADDR_W-1:0]  r_clr, n_clr;

    logic [PROD_W-1:0]  req_cells;
    logic               req_invalid;
    logic [PROD_W-1:0]  ent_cells;
    logic [SIDE_W-1:0]  half_w;
    logic [SIDE_W-1:0]  half_h;
    logic [SIDE_W-1:0]  half_cur;
    logic [SIDE_W-1:0]  side;
    logic [SIDE_W-1:0]  other;
    logic [SIDE_W-1:0]  rest;
    logic [PIECE_W-1:0] j_rest;
    logic [PIECE_W-1:0] j_last;
    logic [PROD_W-1:0]  cap_a;
    logic [PROD_W-1:0]  cap_b;
    logic               cand_ok;
    logic               cand_last;
    logic [ADDR_W-1:0]  ent_addr;
    logic [ADDR_W-1:0]  sub_addr_a;
    logic [ADDR_W-1:0]  sub_addr_b;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  waddr;
    logic [AREA_W-1:0]  wdata;
    logic               we;
    logic [AREA_W-1:0]  rd_a;
    logic [AREA_W-1:0]  rd_b;
    logic [AREA_W-1:0]  cand_max;

    // Request range check on the input channel.
    assign req_cells   = PROD_W'(i_rect_width) * PROD_W'(i_rect_height);
    assign req_invalid = (i_rect_width == '0) || (i_rect_height == '0)
                      || (32'(i_rect_width) > MAX_WIDTH) || (32'(i_rect_height) > MAX_HEIGHT)
                      || (i_piece_count == '0) || (PROD_W'(i_piece_count) > req_cells);

    // Current entry.
    assign ent_cells = PROD_W'(r_cw) * PROD_W'(r_ch);
    assign ent_addr  = slot_of(r_cw, r_ch, r_cp);

    // Split candidate: cut at r_i along the chosen side, r_j pieces go left/top.
    assign half_w   = r_cw >> 1;
    assign half_h   = r_ch >> 1;
    assign half_cur = (r_dir == DIR_HORIZ) ? half_h : half_w;
    assign side     = (r_dir == DIR_HORIZ) ? r_ch : r_cw;
    assign other    = (r_dir == DIR_HORIZ) ? r_cw : r_ch;
    assign rest     = side - r_i;
    assign j_rest   = r_cp - r_j;
    assign j_last   = r_cp - PIECE_W'(1);
    assign cap_a    = PROD_W'(r_i) * PROD_W'(other);
    assign cap_b    = PROD_W'(rest) * PROD_W'(other);
    assign cand_ok  = (PROD_W'(r_j) <= cap_a) && (PROD_W'(j_rest) <= cap_b);
    assign cand_last = (r_j == j_last) && (r_i == half_cur)
                    && ((r_dir == DIR_HORIZ) || (half_h == '0));

    assign sub_addr_a = (r_dir == DIR_HORIZ) ? slot_of(r_cw, r_i, r_j)
                                             : slot_of(r_i, r_ch, r_j);
    assign sub_addr_b = (r_dir == DIR_HORIZ) ? slot_of(r_cw, rest, j_rest)
                                             : slot_of(rest, r_ch, j_rest);

    // Table ports.
    assign raddr_a = i_cmd.cand_step ? sub_addr_a : ent_addr;
    assign we      = i_cmd.clr_step || i_cmd.ent_wr;
    assign waddr   = i_cmd.clr_step ? r_clr : ent_addr;
    assign wdata   = i_cmd.clr_step ? '0 : r_best;

    gcut_ram #(
        .WIDTH (AREA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (sub_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign cand_max = (rd_a > rd_b) ? rd_a : rd_b;

    always_comb begin
        n_w    = r_w;
        n_h    = r_h;
        n_p    = r_p;
        n_inv  = r_inv;
        n_cw   = r_cw;
        n_ch   = r_ch;
        n_cp   = r_cp;
        n_dir  = r_dir;
        n_i    = r_i;
        n_j    = r_j;
        n_best = r_best;
        n_ans  = r_ans;
        n_clr  = r_clr;
        n_pend = i_cmd.cand_step && cand_ok;

        if (i_cmd.clr_step) begin
            n_clr = r_clr + ADDR_W'(1);
        end

        if (i_cmd.load) begin
            n_w   = i_rect_width;
            n_h   = i_rect_height;
            n_p   = i_piece_count;
            n_inv = req_invalid;
            n_cw  = SIDE_W'(1);
            n_ch  = SIDE_W'(1);
            n_cp  = PIECE_W'(1);
        end

        // Entries are visited width fastest, then height, then piece count,
        // so every sub-answer an entry needs is settled before it.
        if (i_cmd.ent_adv) begin
            n_ans = i_cmd.ent_wr ? r_best : rd_a;
            if (r_cw != r_w) begin
                n_cw = r_cw + SIDE_W'(1);
            end else begin
                n_cw = SIDE_W'(1);
                if (r_ch != r_h) begin
                    n_ch = r_ch + SIDE_W'(1);
                end else begin
                    n_ch = SIDE_W'(1);
                    n_cp = r_cp + PIECE_W'(1);
                end
            end
        end

        if (i_cmd.ent_init) begin
            n_best = AREA_W'(ent_cells);
            n_dir  = (half_w == '0) ? DIR_HORIZ : DIR_VERT;
            n_i    = SIDE_W'(1);
            n_j    = PIECE_W'(1);
        end else if (r_pend && (cand_max < r_best)) begin
            n_best = cand_max;
        end

        if (i_cmd.cand_step) begin
            if (r_j != j_last) begin
                n_j = r_j + PIECE_W'(1);
            end else begin
                n_j = PIECE_W'(1);
                if (r_i != half_cur) begin
                    n_i = r_i + SIDE_W'(1);
                end else begin
                    n_i   = SIDE_W'(1);
                    n_dir = DIR_HORIZ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_clr  <= '0;
            r_best <= '0;
        end else begin
            r_pend <= n_pend;
            r_clr  <= n_clr;
            r_best <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_h   <= n_h;
        r_p   <= n_p;
        r_inv <= n_inv;
        r_cw  <= n_cw;
        r_ch  <= n_ch;
        r_cp  <= n_cp;
        r_dir <= n_dir;
        r_i   <= n_i;
        r_j   <= n_j;
        r_ans <= n_ans;
    end

    assign o_sts.clr_last       = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_sts.req_invalid    = req_invalid;
    assign o_sts.ent_infeasible = (PROD_W'(r_cp) > ent_cells);
    assign o_sts.ent_known      = (rd_a != '0);
    assign o_sts.ent_single     = (r_cp == PIECE_W'(1));
    assign o_sts.cand_last      = cand_last;
    assign o_sts.sweep_last     = (r_cw == r_w) && (r_ch == r_h) && (r_cp == r_p);

    assign o_max_piece_area = r_inv ? '0 : RESULT_W'(r_ans);
    assign o_invalid        = r_inv;

    // Zero marks an entry as not yet computed, so no computed answer may be zero.
    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ent_wr |-> (r_best != '0))
        else $error("zero answer written to the table");

    // Both halves of a feasible split must already be settled in the table.
    a_sub_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((rd_a != '0) && (rd_b != '0)))
        else $error("split candidate read an entry that was never computed");

    // The running minimum only falls between two search starts.
    a_best_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ent_init |=> (r_best <= $past(r_best)))
        else $error("running minimum grew during a split search");
endmodule

@@ sv/guillotine_cut_min_max_area_core.sv @@
// ----------------------------------------------------------------------------
// guillotine_cut_min_max_area_core: smallest largest piece under guillotine cuts
// Top level: request/response channels around the controller and datapath.
// ----------------------------------------------------------------------------
// Each request beat gives a rectangle's width and height and a piece count;
// the response beat gives the least possible area of the largest piece when
// the rectangle is cut into that many integer rectangles by straight,
// edge-to-edge cuts, or the invalid flag (with area 0) when a side is zero or
// larger than its parameter, or the piece count is zero or exceeds the number
// of unit cells. Answers live in a table of (MAX_WIDTH*MAX_HEIGHT)^2 entries
// that persists across requests. After reset the block first clears that
// table, one entry per cycle (65536 entries with the default parameters),
// and accepts no request until the pass is over. A valid request then sweeps
// every entry with width up to the request's width, height up to its height
// and piece count up to its count, in rising piece count: an entry with more
// pieces than cells is skipped, an entry already in the table is read back
// and reused, a single-piece entry is written with its cell count, and any
// other new entry runs a split search that tries one cut position and piece
// split per cycle through the table's two read ports. A request that reuses
// a filled table needs no split search; a rejected request answers without
// a sweep. One request is in work at a time: the next is taken after the
// response beat is accepted.
// ----------------------------------------------------------------------------
module guillotine_cut_min_max_area_core #(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcut_req_if.sink   i_req,
    gcut_rsp_if.source o_rsp
);
    import gcut_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    // Sequencing: clearing pass, sweep over entries, split search, handshakes.
    gcut_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Request registers, iterators, running minimum and the answer table.
    gcut_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rect_width     (i_req.rect_width),
        .i_rect_height    (i_req.rect_height),
        .i_piece_count    (i_req.piece_count),
        .o_max_piece_area (o_rsp.max_piece_area),
        .o_invalid        (o_rsp.invalid),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
endmodule
